[hdl/bqdf1_pkg.sv]
// Shared constants and types for the direct form I biquad filter.
package bqdf1_pkg;

  // Design constants
  localparam int unsigned Channels     = 2;
  localparam int unsigned SampleBits   = 24;
  localparam int unsigned CoefFracBits = 16;
  localparam int unsigned CoefBits     = CoefFracBits + 2;
  localparam int unsigned ChannelBits  = 1;
  localparam int unsigned ChanAddrBits = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned ProdBits     = CoefBits + SampleBits;
  localparam int unsigned AccBits      = ProdBits + 3;
  localparam int unsigned OutqDepth    = 3;
  localparam int unsigned OutqPtrBits  = $clog2(OutqDepth);
  localparam int unsigned OutqLvlBits  = $clog2(OutqDepth + 1);

  // Coefficient register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CfgB0 = 3'd0,
    CfgB1 = 3'd1,
    CfgB2 = 3'd2,
    CfgA1 = 3'd3,
    CfgA2 = 3'd4
  } cfg_idx_e;

  // Filter coefficients, Q2.CoefFracBits
  typedef struct packed {
    logic signed [CoefBits-1:0] b0;
    logic signed [CoefBits-1:0] b1;
    logic signed [CoefBits-1:0] b2;
    logic signed [CoefBits-1:0] a1;
    logic signed [CoefBits-1:0] a2;
  } coef_t;

  // History of one channel, one memory word
  typedef struct packed {
    logic signed [SampleBits-1:0] x1;
    logic signed [SampleBits-1:0] x2;
    logic signed [SampleBits-1:0] y1;
    logic signed [SampleBits-1:0] y2;
  } hist_t;

  // One result word
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic [ChannelBits-1:0]       channel;
  } out_word_t;

  localparam logic [CoefBits-1:0] CoefOne = {2'b01, {CoefFracBits{1'b0}}};

endpackage

[hdl/bqdf1_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bqdf1_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port, read port returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/bqdf1_mac.sv]
// History read-modify-write and the biquad multiply-accumulate stage.
module bqdf1_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic signed [bqdf1_pkg::SampleBits-1:0] sample_i,
  input  logic [bqdf1_pkg::ChannelBits-1:0]    channel_i,
  input  bqdf1_pkg::coef_t                     coef_i,
  output logic                                 busy_o,
  output logic                                 push_o,
  output bqdf1_pkg::out_word_t                 word_o
);
  import bqdf1_pkg::*;

  localparam int unsigned HistBits = $bits(hist_t);
  localparam int unsigned ShBits   = AccBits - CoefFracBits;
  localparam logic signed [AccBits-1:0] RoundBias =
    {{(AccBits - CoefFracBits){1'b0}}, 1'b1, {(CoefFracBits - 1){1'b0}}};
  localparam logic signed [SampleBits-1:0] SatMax = {1'b0, {(SampleBits - 1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SatMin = {1'b1, {(SampleBits - 1){1'b0}}};

  logic                          s1_vld_q;
  logic signed [SampleBits-1:0]  s1_sample_q;
  logic [ChannelBits-1:0]        s1_chan_q;
  logic                          rd_vld_q;
  logic [Channels-1:0]           chan_vld_q;
  logic                          fwd_vld_q;
  logic [ChanAddrBits-1:0]       fwd_addr_q;
  hist_t                         fwd_data_q;

  logic [ChanAddrBits-1:0]       rd_addr;
  logic [ChanAddrBits-1:0]       s1_addr;
  logic                          s1_in_range;
  logic [HistBits-1:0]           ram_rdata;
  hist_t                         hist;
  hist_t                         hist_new;
  logic                          we;
  logic signed [ProdBits-1:0]    p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [AccBits-1:0]     acc;
  logic [ShBits-1:0]             shifted;
  logic signed [SampleBits-1:0]  y_sat;

  assign rd_addr     = ChanAddrBits'(channel_i);
  assign s1_addr     = ChanAddrBits'(s1_chan_q);
  assign s1_in_range = (32'(s1_chan_q) < 32'(Channels));

  // Advance the item into the compute stage, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sample_q <= sample_i;
    s1_chan_q   <= channel_i;
  end

  // Track which channel histories were ever written; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      fwd_vld_q  <= 1'b0;
    end else begin
      if (we) begin
        chan_vld_q[s1_addr] <= 1'b1;
      end
      rd_vld_q  <= (32'(rd_addr) < 32'(Channels)) && chan_vld_q[rd_addr];
      fwd_vld_q <= we;
    end
  end

  // Hold the last write for a read issued on the same edge
  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_addr;
    fwd_data_q <= hist_new;
  end

  bqdf1_ram #(
    .Width (HistBits),
    .Depth (Channels)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_addr),
    .wdata_i (hist_new),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Select history: forwarded write, stored word, or zero
  always_comb begin
    priority if (fwd_vld_q && (fwd_addr_q == s1_addr)) begin
      hist = fwd_data_q;
    end else if (rd_vld_q) begin
      hist = hist_t'(ram_rdata);
    end else begin
      hist = '0;
    end
  end

  // Five products and their sum with rounding bias
  always_comb begin
    p_b0 = coef_i.b0 * s1_sample_q;
    p_b1 = coef_i.b1 * hist.x1;
    p_b2 = coef_i.b2 * hist.x2;
    p_a1 = coef_i.a1 * hist.y1;
    p_a2 = coef_i.a2 * hist.y2;
    acc  = AccBits'(p_b0) + AccBits'(p_b1) + AccBits'(p_b2)
         - AccBits'(p_a1) - AccBits'(p_a2) + RoundBias;
  end

  // Drop fraction bits and clamp to the sample range
  always_comb begin
    shifted = acc[AccBits-1:CoefFracBits];
    if (shifted[ShBits-1:SampleBits-1] == {(ShBits - SampleBits + 1){1'b0}} ||
        shifted[ShBits-1:SampleBits-1] == {(ShBits - SampleBits + 1){1'b1}}) begin
      y_sat = $signed(shifted[SampleBits-1:0]);
    end else if (shifted[ShBits-1]) begin
      y_sat = SatMin;
    end else begin
      y_sat = SatMax;
    end
  end

  // Shift the channel history and write it back
  always_comb begin
    hist_new.x1 = s1_sample_q;
    hist_new.x2 = hist.x1;
    hist_new.y1 = y_sat;
    hist_new.y2 = hist.y1;
    we          = s1_vld_q && s1_in_range;
  end

  assign busy_o         = s1_vld_q;
  assign push_o         = s1_vld_q;
  assign word_o.sample  = s1_in_range ? y_sat : '0;
  assign word_o.channel = s1_chan_q;

endmodule

[hdl/bqdf1_outq.sv]
// Small result queue that decouples the compute stage from output stalls.
module bqdf1_outq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  bqdf1_pkg::out_word_t                word_i,
  input  logic                                stall_i,
  output logic                                valid_o,
  output bqdf1_pkg::out_word_t                word_o,
  output logic [bqdf1_pkg::OutqLvlBits-1:0]   level_o
);
  import bqdf1_pkg::*;

  out_word_t              buf_q [OutqDepth];
  logic [OutqPtrBits-1:0] wptr_q, rptr_q;
  logic [OutqLvlBits-1:0] level_q;
  logic                   pop;

  assign pop = valid_o && !stall_i;

  // Advance pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == OutqPtrBits'(OutqDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == OutqPtrBits'(OutqDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      unique case ({push_i, pop})
        2'b10:   level_q <= level_q + 1'b1;
        2'b01:   level_q <= level_q - 1'b1;
        default: level_q <= level_q;
      endcase
    end
  end

  // Store words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= word_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign word_o  = buf_q[rptr_q];
  assign level_o = level_q;

endmodule

[hdl/biquad_direct_form_one_filter_top.sv]
// Top level of the direct form I biquad filter.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+---------------------------
//   in      | to block  | in_valid_i / in_stall_o | sample_in_i, channel_in_i
//   out     | from block| out_valid_o / out_stall_i| sample_out_o, channel_out_o
//   cfg     | to block  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One word per cycle while in_stall_o is low; each result is registered in the
// compute stage and in the result queue before it shows on the output. The rate
// is set by the per-channel history memory, which is read on accept and written
// back the next cycle, with a one-deep forward path. Reset loads b0 = 1.0,
// clears the other taps and marks every channel history as unwritten, so it
// reads as zero; no clearing pass is needed. A three-word result queue absorbs
// output stalls; in_stall_o rises when three words are in flight.
module biquad_direct_form_one_filter_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [bqdf1_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [bqdf1_pkg::CoefBits-1:0]          cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [bqdf1_pkg::SampleBits-1:0] sample_in_i,
  input  logic [bqdf1_pkg::ChannelBits-1:0]       channel_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [bqdf1_pkg::SampleBits-1:0] sample_out_o,
  output logic [bqdf1_pkg::ChannelBits-1:0]       channel_out_o
);
  import bqdf1_pkg::*;

  coef_t                  coef_q;
  logic                   accept;
  logic                   busy;
  logic                   push;
  out_word_t              mac_word;
  out_word_t              out_word;
  logic [OutqLvlBits-1:0] level;

  // Coefficient registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= CoefOne;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgB0:   coef_q.b0 <= cfg_data_i;
        CfgB1:   coef_q.b1 <= cfg_data_i;
        CfgB2:   coef_q.b2 <= cfg_data_i;
        CfgA1:   coef_q.a1 <= cfg_data_i;
        CfgA2:   coef_q.a2 <= cfg_data_i;
        default: coef_q    <= coef_q;
      endcase
    end
  end

  // Stall when the queue could not hold every word in flight
  assign in_stall_o = (OutqLvlBits'(busy) + level) >= OutqLvlBits'(OutqDepth);
  assign accept     = in_valid_i && !in_stall_o;

  bqdf1_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .sample_i  (sample_in_i),
    .channel_i (channel_in_i),
    .coef_i    (coef_q),
    .busy_o    (busy),
    .push_o    (push),
    .word_o    (mac_word)
  );

  bqdf1_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (mac_word),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .word_o  (out_word),
    .level_o (level)
  );

  assign sample_out_o  = out_word.sample;
  assign channel_out_o = out_word.channel;

endmodule

[hdl/bqdf1_chk.sv]
// Port-level checks for the biquad filter top level, bound to it.
module bqdf1_chk (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input logic [bqdf1_pkg::ChannelBits-1:0]       channel_in_i,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic signed [bqdf1_pkg::SampleBits-1:0] sample_out_o,
  input logic [bqdf1_pkg::ChannelBits-1:0]       channel_out_o
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(sample_out_o) && $stable(channel_out_o))
    else $error("stalled result word changed");

  // The output is valid once an accepted word has passed the compute stage into the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted word did not reach the output");

  // No stall while nothing waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output");

  // Through an empty pipeline the channel is echoed in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_valid_o |=>
      channel_out_o == $past(channel_in_i, 2))
    else $error("channel not echoed");

endmodule

bind biquad_direct_form_one_filter_top bqdf1_chk u_bqdf1_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .channel_in_i  (channel_in_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sample_out_o  (sample_out_o),
  .channel_out_o (channel_out_o)
);

[bench/biquad_direct_form_one_filter_top_tb.sv]
// Testbench for the direct form I biquad filter: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module biquad_direct_form_one_filter_top_tb;
  import bqdf1_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned IdlePercent  = 19;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned PhaseWords   = 200;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned TailCycles   = 8;

  localparam logic signed [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic [CoefBits-1:0] CoefMax  = {1'b0, {(CoefBits-1){1'b1}}};
  localparam logic [CoefBits-1:0] CoefMin  = {1'b1, {(CoefBits-1){1'b0}}};
  localparam logic [CoefBits-1:0] CoefHalf = CoefOne >> 1;
  localparam longint SatHigh = (longint'(1) << (SampleBits - 1)) - 1;
  localparam longint SatLow  = -(longint'(1) << (SampleBits - 1));

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]         cfg_idx_i = '0;
  logic [CoefBits-1:0]           cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SampleBits-1:0]  sample_in_i = '0;
  logic [ChannelBits-1:0]        channel_in_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SampleBits-1:0]  sample_out_o;
  logic [ChannelBits-1:0]        channel_out_o;

  // Predictor state: coefficients and per-channel history
  coef_t                         coefs;
  logic signed [SampleBits-1:0]  past_x1 [Channels] = '{default: '0};
  logic signed [SampleBits-1:0]  past_x2 [Channels] = '{default: '0};
  logic signed [SampleBits-1:0]  past_y1 [Channels] = '{default: '0};
  logic signed [SampleBits-1:0]  past_y2 [Channels] = '{default: '0};

  out_word_t                     filtered_q [$];
  int unsigned                   error_count = 0;
  int unsigned                   quiet_cycles = 0;
  logic                          steady_flow = 1'b0;

  biquad_direct_form_one_filter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .channel_in_i (channel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .channel_out_o(channel_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run one sample through the filter and advance that channel's history
  function automatic out_word_t filter_sample(input logic signed [SampleBits-1:0] x,
                                              input logic [ChannelBits-1:0] ch);
    out_word_t word;
    longint    acc;
    longint    y;
    word.channel = ch;
    if (ch >= Channels) begin
      word.sample = '0;
      return word;
    end
    acc = longint'($signed(coefs.b0)) * longint'(x)
        + longint'($signed(coefs.b1)) * longint'(past_x1[ch])
        + longint'($signed(coefs.b2)) * longint'(past_x2[ch])
        - longint'($signed(coefs.a1)) * longint'(past_y1[ch])
        - longint'($signed(coefs.a2)) * longint'(past_y2[ch]);
    acc = acc + (longint'(1) << (CoefFracBits - 1));
    y = acc >>> CoefFracBits;
    if (y > SatHigh) begin
      y = SatHigh;
    end else if (y < SatLow) begin
      y = SatLow;
    end
    past_x2[ch] = past_x1[ch];
    past_x1[ch] = x;
    past_y2[ch] = past_y1[ch];
    past_y1[ch] = y[SampleBits-1:0];
    word.sample = y[SampleBits-1:0];
    return word;
  endfunction

  function automatic logic signed [SampleBits-1:0] pick_sample();
    int unsigned pick;
    int          value;
    pick = $urandom_range(99);
    if (pick < 40) begin
      value = int'($urandom);
    end else if (pick < 60) begin
      value = int'($urandom_range(512)) - 256;
    end else if (pick < 75) begin
      case ($urandom_range(4))
        0:       value = int'(SampleMax);
        1:       value = int'(SampleMin);
        2:       value = 0;
        3:       value = 1;
        default: value = -1;
      endcase
    end else begin
      value = int'($urandom_range(1 << 21)) - (1 << 20);
    end
    return value[SampleBits-1:0];
  endfunction

  function automatic logic [CoefBits-1:0] pick_coef(input int lo, input int hi);
    int value;
    value = lo + int'($urandom_range(hi - lo));
    return value[CoefBits-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ERROR %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // Send one word, hold it until taken, then record its expected result
  task automatic send_word(input logic signed [SampleBits-1:0] x,
                           input logic [ChannelBits-1:0] ch);
    while (!steady_flow && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_in_i  <= x;
    channel_in_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    filtered_q.push_back(filter_sample(x, ch));
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_register(input logic [CfgIdxBits-1:0] idx,
                                input logic [CoefBits-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgB0:   coefs.b0 = value;
      CfgB1:   coefs.b1 = value;
      CfgB2:   coefs.b2 = value;
      CfgA1:   coefs.a1 = value;
      CfgA2:   coefs.a2 = value;
      default: ;
    endcase
  endtask

  task automatic load_coefs(input logic [CoefBits-1:0] b0, input logic [CoefBits-1:0] b1,
                            input logic [CoefBits-1:0] b2, input logic [CoefBits-1:0] a1,
                            input logic [CoefBits-1:0] a2);
    wait_idle();
    write_register(CfgB0, b0);
    write_register(CfgB1, b1);
    write_register(CfgB2, b2);
    write_register(CfgA1, a1);
    write_register(CfgA2, a2);
    cfg_we_i <= 1'b0;
  endtask

  // Reset taps pass the input through: full-scale and tiny samples on both channels
  task automatic test_passthrough_extremes();
    send_word(SampleMax, 1'b0);
    send_word(SampleMin, 1'b1);
    send_word('0, 1'b0);
    send_word(1, 1'b1);
    send_word(-1, 1'b0);
    send_word(SampleMax, 1'b1);
  endtask

  // Exact halves round toward plus infinity
  task automatic test_round_half();
    load_coefs(CoefHalf, '0, '0, '0, '0);
    send_word(1, 1'b0);
    send_word(-1, 1'b1);
    send_word(3, 1'b0);
    send_word(-3, 1'b1);
  endtask

  // Writes past the last coefficient index leave the taps alone
  task automatic test_unused_index();
    wait_idle();
    for (int idx = int'(CfgA2) + 1; idx < (1 << CfgIdxBits); idx++) begin
      write_register(idx[CfgIdxBits-1:0], CoefMax);
    end
    cfg_we_i <= 1'b0;
    send_word(5, 1'b0);
    send_word(-7, 1'b1);
  endtask

  // Extreme taps drive the sum past full scale both ways
  task automatic test_saturation();
    load_coefs(CoefMax, CoefMax, CoefMax, CoefMax, CoefMax);
    send_word(SampleMax, 1'b0);
    send_word(SampleMax, 1'b0);
    send_word(SampleMin, 1'b1);
    send_word(SampleMin, 1'b1);
    load_coefs(CoefMin, CoefMin, CoefMin, CoefMin, CoefMin);
    send_word(SampleMax, 1'b0);
    send_word(SampleMin, 1'b0);
    send_word(SampleMax, 1'b1);
  endtask

  // Random streams under several tap sets, one phase without idling
  task automatic test_random_filters();
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: load_coefs(CoefMax, CoefMin, CoefMax, CoefMin, CoefMax);
        1: load_coefs(CoefMin, CoefMax, CoefMin, CoefMax, CoefMin);
        2: load_coefs(pick_coef(-131072, 131071), pick_coef(-131072, 131071),
                      pick_coef(-131072, 131071), pick_coef(-131072, 131071),
                      pick_coef(-131072, 131071));
        default: load_coefs(pick_coef(-32768, 32768), pick_coef(-32768, 32768),
                            pick_coef(-32768, 32768), pick_coef(-98304, 98304),
                            pick_coef(-32768, 57344));
      endcase
      steady_flow = (phase == 3);
      for (int n = 0; n < PhaseWords; n++) begin
        send_word(pick_sample(), ChannelBits'($urandom_range(Channels - 1)));
      end
    end
    steady_flow = 1'b0;
  endtask

  // Random output stall
  always @(posedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(99) < IdlePercent);
  end

  // Compare each taken result word with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected result word, sample", int'(sample_out_o), 0);
      end else begin
        want = filtered_q.pop_front();
        if (sample_out_o !== want.sample) begin
          report_mismatch("sample_out", int'(sample_out_o), int'(want.sample));
        end
        if (channel_out_o !== want.channel) begin
          report_mismatch("channel_out", int'(channel_out_o), int'(want.channel));
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("biquad_direct_form_one_filter_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    coefs.b0 = CoefOne;
    coefs.b1 = '0;
    coefs.b2 = '0;
    coefs.a1 = '0;
    coefs.a2 = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough_extremes();
    test_round_half();
    test_unused_index();
    test_saturation();
    test_random_filters();

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("biquad_direct_form_one_filter_top: match");
    end else begin
      $display("biquad_direct_form_one_filter_top: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bqdf1_pkg.sv
hdl/bqdf1_ram.sv
hdl/bqdf1_mac.sv
hdl/bqdf1_outq.sv
hdl/biquad_direct_form_one_filter_top.sv
hdl/bqdf1_chk.sv
bench/biquad_direct_form_one_filter_top_tb.sv
